// ===== rtl/bbwf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbwf_pkg: shared constants and helpers
// Tile geometry, register map, luma coefficients and small arithmetic helpers
// for the binary block weighted feature extractor.
// ----------------------------------------------------------------------------
package bbwf_pkg;

  localparam int TILE        = 5;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;

  localparam int SUM_W       = 6;   // tile sum, 0..45
  localparam int IDX_W       = 16;  // tile index, wraps mod 2^16
  localparam int PIX_W       = 8;
  localparam int SIZE_W      = 11;  // image_width / image_height registers
  localparam int THR_W       = 8;

  localparam int WIDTH_RESET     = 640;
  localparam int HEIGHT_RESET    = 480;
  localparam int THRESHOLD_RESET = 127;

  // Register map: byte address = 4 * index
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_DARK_THRESHOLD = 2'd2;

  // Luma coefficients 0.2126 / 0.7152 / 0.0722 in Q0.24, rounded up.
  // Rounding up keeps floor(x*C >> 24) equal to floor(K*x/10000) for
  // 8-bit x: the error stays below 255/2^24, under the 1/10000 step.
  localparam int LUMA_FRAC = 24;
  localparam logic [LUMA_FRAC-1:0] LUMA_K_RED =
    LUMA_FRAC'((64'd2126 * 64'd16777216 + 64'd9999) / 64'd10000);
  localparam logic [LUMA_FRAC-1:0] LUMA_K_GREEN =
    LUMA_FRAC'((64'd7152 * 64'd16777216 + 64'd9999) / 64'd10000);
  localparam logic [LUMA_FRAC-1:0] LUMA_K_BLUE =
    LUMA_FRAC'((64'd722 * 64'd16777216 + 64'd9999) / 64'd10000);

  // Mask rows 32123 / 22122 / 11111 / 22122 / 32123
  function automatic logic [1:0] tile_weight(logic [2:0] ox, logic [2:0] oy);
    logic edge_x;
    logic edge_y;
    edge_x = (ox == 3'd0) || (ox == 3'(TILE - 1));
    edge_y = (oy == 3'd0) || (oy == 3'(TILE - 1));
    if ((ox == 3'(TILE / 2)) || (oy == 3'(TILE / 2))) return 2'd1;
    else if (edge_x && edge_y)                        return 2'd3;
    else                                              return 2'd2;
  endfunction

  function automatic logic [31:0] clamp_size(logic [31:0] v, logic [31:0] hi);
    if (v < 32'(TILE)) return 32'(TILE);
    else if (v > hi)   return hi;
    else               return v;
  endfunction

  // floor(v/5) by reciprocal: 52429*5 = 2^18 + 1, exact for v < 2^18
  function automatic logic [31:0] div_tile(logic [15:0] v);
    logic [33:0] prod;
    prod = 34'(v) * 34'd52429;
    return 32'(prod >> 18);
  endfunction

endpackage

// ===== rtl/binary_block_weighted_features.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_block_weighted_features: zoning features over a binary ink map
// Pipeline: an input transfer is registered in stage 1, then in the output register that drives out_valid.
// Throughput: one pixel per clock unless the output stalls; the per-column sum memory
//   does one read-modify-write per cycle (read at entry, written back in stage 1).
// Reset (sync, rst_n low): position counters and valids clear, registers
//   return to 640 x 480 / threshold 127. The sum memory is not cleared;
//   the first pixel of every tile overwrites its column entry.
// ----------------------------------------------------------------------------
module binary_block_weighted_features #(
  parameter int MAX_WIDTH  = bbwf_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = bbwf_pkg::MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // pixel input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bbwf_pkg::PIX_W-1:0]       in_blue,
  input  logic [bbwf_pkg::PIX_W-1:0]       in_green,
  input  logic [bbwf_pkg::PIX_W-1:0]       in_red,
  input  logic [bbwf_pkg::PIX_W-1:0]       in_alpha,   // ignored: zero weight
  // tile result
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bbwf_pkg::SUM_W-1:0]       out_tile_sum,
  output logic [bbwf_pkg::IDX_W-1:0]       out_tile_index,
  output logic                             out_frame_done,
  // register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bbwf_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int TILE      = bbwf_pkg::TILE;
  localparam int SUM_DEPTH = MAX_WIDTH / TILE;
  localparam int WW        = $clog2(MAX_WIDTH + 1);    // clamped width
  localparam int HW        = $clog2(MAX_HEIGHT + 1);   // clamped height
  localparam int PCW       = $clog2(MAX_WIDTH);        // pixel column
  localparam int PRW       = $clog2(MAX_HEIGHT);       // pixel row
  localparam int TCW       = $clog2(SUM_DEPTH + 1);    // tile column / tiles per row
  localparam int AW        = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
  localparam int SW        = bbwf_pkg::SUM_W;
  localparam int IW        = bbwf_pkg::IDX_W;

  localparam logic [WW-1:0] W_RESET =
    WW'(bbwf_pkg::clamp_size(32'(bbwf_pkg::WIDTH_RESET), 32'(MAX_WIDTH)));
  localparam logic [HW-1:0] H_RESET =
    HW'(bbwf_pkg::clamp_size(32'(bbwf_pkg::HEIGHT_RESET), 32'(MAX_HEIGHT)));
  localparam logic [TCW-1:0] TPR_RESET = TCW'(bbwf_pkg::div_tile(16'(W_RESET)));

  // --------------------------------------------------------------------------
  // Registers. The clamped size and tiles-per-row are worked out at the
  // write itself, so they are good on the very next pixel.
  // --------------------------------------------------------------------------
  logic [bbwf_pkg::SIZE_W-1:0] width_r, height_r;
  logic [bbwf_pkg::THR_W-1:0]  thresh_r;
  logic [WW-1:0]               w_eff_r;
  logic [HW-1:0]               h_eff_r;
  logic [TCW-1:0]              tpr_r;
  logic                        cfg_wr;
  logic [WW-1:0]               w_eff_nxt;
  logic [HW-1:0]               h_eff_nxt;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    w_eff_nxt = WW'(bbwf_pkg::clamp_size(32'(pwdata[bbwf_pkg::SIZE_W-1:0]),
                                         32'(MAX_WIDTH)));
    h_eff_nxt = HW'(bbwf_pkg::clamp_size(32'(pwdata[bbwf_pkg::SIZE_W-1:0]),
                                         32'(MAX_HEIGHT)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bbwf_pkg::SIZE_W'(bbwf_pkg::WIDTH_RESET);
      height_r <= bbwf_pkg::SIZE_W'(bbwf_pkg::HEIGHT_RESET);
      thresh_r <= bbwf_pkg::THR_W'(bbwf_pkg::THRESHOLD_RESET);
      w_eff_r  <= W_RESET;
      h_eff_r  <= H_RESET;
      tpr_r    <= TPR_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        bbwf_pkg::REG_IMAGE_WIDTH: begin
          width_r <= pwdata[bbwf_pkg::SIZE_W-1:0];
          w_eff_r <= w_eff_nxt;
          tpr_r   <= TCW'(bbwf_pkg::div_tile(16'(w_eff_nxt)));
        end
        bbwf_pkg::REG_IMAGE_HEIGHT: begin
          height_r <= pwdata[bbwf_pkg::SIZE_W-1:0];
          h_eff_r  <= h_eff_nxt;
        end
        bbwf_pkg::REG_DARK_THRESHOLD: begin
          thresh_r <= pwdata[bbwf_pkg::THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      bbwf_pkg::REG_IMAGE_WIDTH:    prdata = 32'(width_r);
      bbwf_pkg::REG_IMAGE_HEIGHT:   prdata = 32'(height_r);
      bbwf_pkg::REG_DARK_THRESHOLD: prdata = 32'(thresh_r);
      default:                      prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake. Stage 1 only holds when it has a result and the output
  // register is full and stalled; otherwise a new pixel enters every cycle.
  // --------------------------------------------------------------------------
  logic out_valid_r;
  logic s1_valid_r;
  logic s1_emit_r;
  logic s1_go;
  logic in_xfer;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!s1_emit_r || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_xfer  = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Stage 0: position counters and tile bookkeeping
  // --------------------------------------------------------------------------
  logic [PCW-1:0] pix_col_r;
  logic [PRW-1:0] pix_row_r;
  logic [2:0]     ox_r, oy_r;
  logic [TCW-1:0] tile_col_r;
  logic [IW-1:0]  row_base_r;

  logic [PRW-1:0] row_start;
  logic           row_ok;
  logic           s0_contrib;
  logic           s0_first;
  logic           s0_emit;
  logic           s0_done;
  logic [IW-1:0]  s0_index;
  logic           row_end;
  logic           frame_end;

  always_comb begin
    row_start  = pix_row_r - PRW'(oy_r);
    row_ok     = (32'(row_start) + 32'(TILE)) <= 32'(h_eff_r);
    s0_contrib = (tile_col_r < tpr_r) && row_ok;
    s0_first   = (ox_r == 3'd0) && (oy_r == 3'd0);
    s0_emit    = s0_contrib && (ox_r == 3'(TILE - 1)) && (oy_r == 3'(TILE - 1));
    s0_index   = row_base_r + IW'(tile_col_r);
    s0_done    = (32'(tile_col_r) + 32'd1 == 32'(tpr_r)) &&
                 (32'(row_start) + 32'(2 * TILE) > 32'(h_eff_r));
    row_end    = (32'(pix_col_r) + 32'd1) >= 32'(w_eff_r);
    frame_end  = (32'(pix_row_r) + 32'd1) >= 32'(h_eff_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_col_r  <= '0;
      pix_row_r  <= '0;
      ox_r       <= '0;
      oy_r       <= '0;
      tile_col_r <= '0;
      row_base_r <= '0;
    end else if (in_xfer) begin
      if (row_end) begin
        pix_col_r  <= '0;
        ox_r       <= '0;
        tile_col_r <= '0;
        if (frame_end) begin
          pix_row_r  <= '0;
          oy_r       <= '0;
          row_base_r <= '0;
        end else begin
          pix_row_r <= PRW'(pix_row_r + 1'b1);
          if (oy_r == 3'(TILE - 1)) begin
            oy_r       <= '0;
            row_base_r <= row_base_r + IW'(tpr_r);
          end else begin
            oy_r <= oy_r + 3'd1;
          end
        end
      end else begin
        pix_col_r <= PCW'(pix_col_r + 1'b1);
        if (ox_r == 3'(TILE - 1)) begin
          ox_r       <= '0;
          tile_col_r <= TCW'(tile_col_r + 1'b1);
        end else begin
          ox_r <= ox_r + 3'd1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Per-tile-column sum memory: read at stage 0, written back in stage 1.
  // --------------------------------------------------------------------------
  logic [SW-1:0] sums_mem [SUM_DEPTH];
  logic [SW-1:0] rd_data_r;
  logic          mem_we;
  logic [AW-1:0] s1_addr_r;
  logic [SW-1:0] s1_sum;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sums_mem[s1_addr_r] <= s1_sum;
    end
    if (in_xfer && s0_contrib) begin
      rd_data_r <= sums_mem[tile_col_r[AW-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: luma, ink mark, weight and accumulate
  // --------------------------------------------------------------------------
  logic                        s1_contrib_r;
  logic                        s1_first_r;
  logic                        s1_done_r;
  logic [1:0]                  s1_weight_r;
  logic [IW-1:0]               s1_index_r;
  // write that landed on the same edge as this pixel's read
  logic                        fwd_valid_r;
  logic [AW-1:0]               fwd_addr_r;
  logic [SW-1:0]               fwd_data_r;
  logic [bbwf_pkg::PIX_W-1:0]  luma;
  logic                        ink;
  logic [SW-1:0]               base_sum;

  bbwf_luma u_luma (
    .clk   (clk),
    .load  (in_xfer),
    .red   (in_red),
    .green (in_green),
    .blue  (in_blue),
    .luma  (luma)
  );

  always_comb begin
    ink    = luma < thresh_r;
    mem_we = s1_go && s1_contrib_r;
    if (s1_first_r)                                base_sum = '0;
    else if (fwd_valid_r && fwd_addr_r == s1_addr_r) base_sum = fwd_data_r;
    else                                           base_sum = rd_data_r;
    s1_sum = base_sum + (ink ? SW'(s1_weight_r) : SW'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r  <= 1'b1;
      fwd_valid_r <= mem_we;
    end else if (s1_go) begin
      s1_valid_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_contrib_r <= s0_contrib;
      s1_first_r   <= s0_first;
      s1_emit_r    <= s0_emit;
      s1_done_r    <= s0_done;
      s1_weight_r  <= bbwf_pkg::tile_weight(ox_r, oy_r);
      s1_addr_r    <= tile_col_r[AW-1:0];
      s1_index_r   <= s0_index;
      fwd_addr_r   <= s1_addr_r;
      fwd_data_r   <= s1_sum;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit_r) begin
      out_tile_sum   <= s1_sum;
      out_tile_index <= s1_index_r;
      out_frame_done <= s1_done_r;
    end
  end

  assign out_valid = out_valid_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without output backpressure");

  a_result_from_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(s1_valid_r) && $past(s1_emit_r)))
    else $error("result appeared without an emitting pixel");

  a_offset_at_row_start: assert property (@(posedge clk) disable iff (!rst_n)
    (pix_col_r == '0) |-> (ox_r == 3'd0 && tile_col_r == '0))
    else $error("tile offset not aligned to row start");

endmodule

// ===== rtl/bbwf_luma.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbwf_luma: fixed-point luma
// Three coefficient products registered on load, then the truncated terms
// are summed after the register.
// ----------------------------------------------------------------------------
module bbwf_luma (
  input  logic                          clk,
  input  logic                          load,
  input  logic [bbwf_pkg::PIX_W-1:0]    red,
  input  logic [bbwf_pkg::PIX_W-1:0]    green,
  input  logic [bbwf_pkg::PIX_W-1:0]    blue,
  output logic [bbwf_pkg::PIX_W-1:0]    luma
);

  localparam int PW = bbwf_pkg::PIX_W + bbwf_pkg::LUMA_FRAC;

  logic [PW-1:0] prod_red_r;
  logic [PW-1:0] prod_green_r;
  logic [PW-1:0] prod_blue_r;
  logic [bbwf_pkg::PIX_W+1:0] luma_sum;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_red_r   <= PW'(red)   * PW'(bbwf_pkg::LUMA_K_RED);
      prod_green_r <= PW'(green) * PW'(bbwf_pkg::LUMA_K_GREEN);
      prod_blue_r  <= PW'(blue)  * PW'(bbwf_pkg::LUMA_K_BLUE);
    end
  end

  // each term truncated separately; total never exceeds 254
  always_comb begin
    luma_sum = (bbwf_pkg::PIX_W + 2)'(prod_red_r[PW-1:bbwf_pkg::LUMA_FRAC])
             + (bbwf_pkg::PIX_W + 2)'(prod_green_r[PW-1:bbwf_pkg::LUMA_FRAC])
             + (bbwf_pkg::PIX_W + 2)'(prod_blue_r[PW-1:bbwf_pkg::LUMA_FRAC]);
    luma     = luma_sum[bbwf_pkg::PIX_W-1:0];
  end

endmodule
